FILE: hw/rtl/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg: shared types for the contiguous sublist matcher
// Item kind codes and the load strobes that the core hands to the lane array.
// ----------------------------------------------------------------------------
package csm_pkg;

  // Width of one list element
  localparam int unsigned ValueW = 32;

  // Kind of an incoming element
  typedef enum logic {
    FuncPattern = 1'b0,
    FuncText    = 1'b1
  } func_e;

  // Load strobes from the core control to the lane array
  typedef struct packed {
    logic pat_load;  // shift a new element into the pattern lanes
    logic txt_load;  // shift a new element into the text window
  } lane_ctl_t;

endpackage

FILE: hw/rtl/contiguous_sublist_matcher_core.sv
// ----------------------------------------------------------------------------
// contiguous_sublist_matcher_core: streaming contiguous sublist matcher
// Checks whether a loaded pattern list occurs as a contiguous run in a text
// list that streams in afterwards.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one element per
//   transaction. func_i = pattern or text. A pattern element with first_i
//   set restarts the pattern; elements past PATTERN_MAX are dropped and
//   flagged. Any pattern element discards text progress.
//   Output channel (out_valid_o/out_ready_i) carries one result per text
//   element with last_i set: found_o and pattern_overflow_o.
//   Throughput: one element per cycle unless a result stalls on out_ready_i,
//   set by a combinational compare of all pattern lanes to the shifted window.
//   Path: an element is captured in the input register and processed once the
//   result register is free; its result is then registered onto out_valid_o.
//   Stall: the input register still takes one element while a result waits;
//   after that in_ready_o drops until out_ready_i frees the result register.
//   Reset: clears the pattern length, text progress, flags and both valid
//   bits; pattern and window lanes hold no defined value until loaded.
// ----------------------------------------------------------------------------
module contiguous_sublist_matcher_core #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               func_i,
  input  logic signed [csm_pkg::ValueW-1:0]  value_i,
  input  logic                               first_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               found_o,
  output logic                               pattern_overflow_o
);

  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1);

  // Input register
  logic                        in_valid_q;
  csm_pkg::func_e              func_q;
  logic [csm_pkg::ValueW-1:0]  value_q;
  logic                        first_q;
  logic                        last_q;

  // Matcher state
  logic [LenW-1:0] pat_len_q, pat_len_d;
  logic [LenW-1:0] seen_q, seen_d;
  logic            match_q, match_d;
  logic            ovf_q, ovf_d;

  // Result register
  logic out_valid_q, out_valid_d;
  logic found_q, found_d;
  logic povf_q, povf_d;

  logic               out_free;
  logic               proc;
  logic               out_load;
  logic [LenW-1:0]    len_base;
  logic               ovf_base;
  logic [LenW-1:0]    seen_next;
  logic               match_next;
  logic               lane_hit;
  csm_pkg::lane_ctl_t lane_ctl;

  // Handshake: process when the result register can take a possible result
  assign out_free   = !out_valid_q || out_ready_i;
  assign proc       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      func_q  <= csm_pkg::func_e'(func_i);
      value_q <= value_i;
      first_q <= first_i;
      last_q  <= last_i;
    end
  end

  // Lane array
  csm_lanes #(
    .PatternMax(PATTERN_MAX)
  ) u_lanes (
    .clk_i    (clk_i),
    .ctl_i    (lane_ctl),
    .value_i  (value_q),
    .pat_len_i(pat_len_q),
    .hit_o    (lane_hit)
  );

  // Next state for one processed transaction
  always_comb begin
    len_base    = first_q ? '0 : pat_len_q;
    ovf_base    = first_q ? 1'b0 : ovf_q;
    seen_next   = (seen_q < LenW'(PATTERN_MAX)) ? seen_q + LenW'(1) : seen_q;
    match_next  = match_q || (pat_len_q == '0) ||
                  ((seen_next >= pat_len_q) && lane_hit);

    lane_ctl    = '0;
    pat_len_d   = pat_len_q;
    ovf_d       = ovf_q;
    seen_d      = seen_q;
    match_d     = match_q;
    out_load    = 1'b0;
    found_d     = found_q;
    povf_d      = povf_q;

    if (proc) begin
      case (func_q)
        csm_pkg::FuncPattern: begin
          if (len_base < LenW'(PATTERN_MAX)) begin
            lane_ctl.pat_load = 1'b1;
            pat_len_d         = len_base + LenW'(1);
            ovf_d             = ovf_base;
          end else begin
            pat_len_d = len_base;
            ovf_d     = 1'b1;
          end
          seen_d  = '0;
          match_d = 1'b0;
        end
        csm_pkg::FuncText: begin
          lane_ctl.txt_load = 1'b1;
          if (last_q) begin
            out_load = 1'b1;
            found_d  = match_next;
            povf_d   = ovf_q;
            seen_d   = '0;
            match_d  = 1'b0;
          end else begin
            seen_d  = seen_next;
            match_d = match_next;
          end
        end
        default: begin
          seen_d = seen_q;
        end
      endcase
    end

    out_valid_d = out_load || (out_valid_q && !out_ready_i);
  end

  // State and result valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q   <= '0;
      seen_q      <= '0;
      match_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pat_len_q   <= pat_len_d;
      seen_q      <= seen_d;
      match_q     <= match_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      found_q <= found_d;
      povf_q  <= povf_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign found_o            = found_q;
  assign pattern_overflow_o = povf_q;

  // Assertions
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pat_len_q <= LenW'(PATTERN_MAX)) && (seen_q <= LenW'(PATTERN_MAX)))
    else $error("pattern length or text count beyond capacity");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (pat_len_q == LenW'(PATTERN_MAX)))
    else $error("overflow flag set with pattern not full");

  a_result_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> ((seen_q == '0) && !match_q && out_valid_o))
    else $error("text progress not cleared after result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !out_load)
    else $error("result register overwritten while stalled");

endmodule

FILE: hw/rtl/csm_lanes.sv
// ----------------------------------------------------------------------------
// csm_lanes: pattern and text shift lanes with parallel compare
// Pattern lane 0 holds the newest pattern element and window lane 0 the newest
// text element, so lane j of each side lines up for the alignment that ends
// at the incoming text element. Lanes at or beyond the pattern length are
// don't-care in the compare.
// ----------------------------------------------------------------------------
module csm_lanes #(
  parameter int unsigned PatternMax = 16
) (
  input  logic                              clk_i,
  input  csm_pkg::lane_ctl_t                ctl_i,
  input  logic [csm_pkg::ValueW-1:0]        value_i,
  input  logic [$clog2(PatternMax+1)-1:0]   pat_len_i,
  output logic                              hit_o
);

  localparam int unsigned LenW = $clog2(PatternMax + 1);

  logic [csm_pkg::ValueW-1:0] pat_q   [PatternMax];
  logic [csm_pkg::ValueW-1:0] pat_d   [PatternMax];
  logic [csm_pkg::ValueW-1:0] win_q   [PatternMax];
  logic [csm_pkg::ValueW-1:0] win_d   [PatternMax];
  logic [PatternMax-1:0]      lane_eq;

  // Shifted lane contents, newest element enters at lane 0
  always_comb begin
    pat_d[0] = value_i;
    win_d[0] = value_i;
    for (int j = 1; j < PatternMax; j++) begin
      pat_d[j] = pat_q[j-1];
      win_d[j] = win_q[j-1];
    end
  end

  // Lane registers: payload only, no reset
  always_ff @(posedge clk_i) begin
    if (ctl_i.pat_load) begin
      pat_q <= pat_d;
    end
    if (ctl_i.txt_load) begin
      win_q <= win_d;
    end
  end

  // Per-lane compare against the window including the incoming element
  always_comb begin
    for (int j = 0; j < PatternMax; j++) begin
      lane_eq[j] = (pat_q[j] == win_d[j]) || (LenW'(j) >= pat_len_i);
    end
  end

  assign hit_o = &lane_eq;

endmodule
